[hdl/rfo_pkg.sv]
`timescale 1ns / 1ps

package rfo_pkg;

    localparam int OP_W       = 2;
    localparam int COORD_IN_W = 20;
    localparam int CHAR_W     = 8;
    localparam int RD_POS_W   = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // wide enough for col * 256 up to 4095 and for x + w - 256
    localparam int COORD_W  = 23;
    localparam int FRAC_ONE = 256;

    localparam logic [CHAR_W-1:0]     RESET_BG   = 8'd32;
    localparam logic [CFG_DATA_W-1:0] RESET_SIZE = 10'd512;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_FILL    = 2'd1,
        OP_OUTLINE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_SIZE  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

endpackage

[hdl/rfo_if.sv]
`timescale 1ns / 1ps

interface rfo_req_if;
    logic                                   valid;
    logic                                   ready;
    rfo_pkg::op_t                           op;
    logic signed [rfo_pkg::COORD_IN_W-1:0]  rect_left;
    logic signed [rfo_pkg::COORD_IN_W-1:0]  rect_top;
    logic signed [rfo_pkg::COORD_IN_W-1:0]  rect_width;
    logic signed [rfo_pkg::COORD_IN_W-1:0]  rect_height;
    logic [rfo_pkg::CHAR_W-1:0]             fill_char;
    logic [rfo_pkg::RD_POS_W-1:0]           read_col;
    logic [rfo_pkg::RD_POS_W-1:0]           read_row;

    modport source (
        output valid, op, rect_left, rect_top, rect_width, rect_height,
               fill_char, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, op, rect_left, rect_top, rect_width, rect_height,
               fill_char, read_col, read_row,
        output ready
    );
endinterface

interface rfo_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rfo_pkg::STATUS_W-1:0]    status;
    logic [rfo_pkg::CHAR_W-1:0]      cell_char;

    modport source (
        output valid, status, cell_char,
        input  ready
    );
    modport sink (
        input  valid, status, cell_char,
        output ready
    );
endinterface

[hdl/rect_fill_outline_raster.sv]
`timescale 1ns / 1ps
// clear: sweeps all MAX_COLS*MAX_ROWS cells, one cell write per cycle on the canvas port
// draw: setup steps on the shared adder form the bounds, then each canvas row is checked and each row hit is
// scanned across the canvas width; a bad size goes straight to done. read: address, memory read, wait, result register
// throughput: one request at a time, the next is taken once the sequencer is back in idle
// reset: control clears at once, then a pass over every cell writes 32 to it
// reset: no request is taken during that pass, configuration writes are taken throughout
module rect_fill_outline_raster #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rfo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfo_pkg::CFG_DATA_W-1:0]     cfg_data,
    rfo_req_if.sink                            req,
    rfo_rsp_if.source                          rsp
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CW     = rfo_pkg::COORD_W;
    localparam int SETUP_STEPS = 6;

    typedef enum logic [7:0] {
        S_SWEEP  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SETUP  = 8'b0000_0100,
        S_ROW    = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_RDDATA = 8'b0010_0000,
        S_RDWAIT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    function automatic logic [COL_W-1:0] clamp_cols(input logic [rfo_pkg::CFG_DATA_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v == '0)
            r = COL_W'(1);
        else if (32'(v) > 32'(MAX_COLS))
            r = COL_W'(MAX_COLS);
        else
            r = COL_W'(v);
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_rows(input logic [rfo_pkg::CFG_DATA_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v == '0)
            r = ROW_W'(1);
        else if (32'(v) > 32'(MAX_ROWS))
            r = ROW_W'(MAX_ROWS);
        else
            r = ROW_W'(v);
        return r;
    endfunction

    state_t                         state_reg;
    logic [COL_W-1:0]               cw_reg;
    logic [ROW_W-1:0]               ch_reg;
    logic [rfo_pkg::CHAR_W-1:0]     bg_reg;

    logic [ADDR_W-1:0]              addr_reg;
    logic [ADDR_W-1:0]              row_base_reg;
    logic [COL_W-1:0]               col_reg;
    logic [ROW_W-1:0]               row_reg;
    logic [2:0]                     step_reg;
    logic [rfo_pkg::CHAR_W-1:0]     char_reg;
    logic                           outline_reg;
    logic                           sweep_cmd_reg;
    logic                           is_read_reg;
    rfo_pkg::status_t               status_reg;
    logic                           row_edge_reg;

    logic signed [CW-1:0]           x_reg, y_reg, w_reg, h_reg;
    logic signed [CW-1:0]           xe_reg, ye_reg, xl_reg, yl_reg, xh_reg, yh_reg;

    logic [rfo_pkg::CHAR_W-1:0]     rd_data_reg;
    logic [rfo_pkg::CHAR_W-1:0]     mem [DEPTH];

    logic                           out_valid_reg;
    logic [rfo_pkg::STATUS_W-1:0]   out_status_reg;
    logic [rfo_pkg::CHAR_W-1:0]     out_char_reg;

    logic signed [CW-1:0]           add_a, add_b, add_sum;
    logic signed [CW-1:0]           cx, ry;
    logic                           row_in, row_edge, col_in, col_edge, hit;
    logic                           row_last, col_last;
    logic                           mem_we;
    logic                           accept;
    logic                           rsp_load;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // shared adder for the rectangle bounds
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                add_a = x_reg;
                add_b = w_reg;
            end
            3'd1:
            begin
                add_a = y_reg;
                add_b = h_reg;
            end
            3'd2:
            begin
                add_a = x_reg;
                add_b = CW'(rfo_pkg::FRAC_ONE);
            end
            3'd3:
            begin
                add_a = y_reg;
                add_b = CW'(rfo_pkg::FRAC_ONE);
            end
            3'd4:
            begin
                add_a = xe_reg;
                add_b = -CW'(rfo_pkg::FRAC_ONE);
            end
            3'd5:
            begin
                add_a = ye_reg;
                add_b = -CW'(rfo_pkg::FRAC_ONE);
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    assign cx = signed'(CW'({col_reg, 8'b0}));
    assign ry = signed'(CW'({row_reg, 8'b0}));

    assign row_in   = (ry >= y_reg) && (ry <= ye_reg);
    assign row_edge = (ry < yl_reg) || (ry > yh_reg);
    assign col_in   = (cx >= x_reg) && (cx <= xe_reg);
    assign col_edge = (cx < xl_reg) || (cx > xh_reg);
    assign hit      = col_in && (!outline_reg || row_edge_reg || col_edge);

    assign row_last = (row_reg == ch_reg - ROW_W'(1));
    assign col_last = (col_reg == cw_reg - COL_W'(1));

    assign mem_we = (state_reg == S_SWEEP) || ((state_reg == S_SCAN) && hit);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= char_reg;
        rd_data_reg <= mem[addr_reg];
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= clamp_cols(rfo_pkg::RESET_SIZE);
            ch_reg <= clamp_rows(rfo_pkg::RESET_SIZE);
            bg_reg <= rfo_pkg::RESET_BG;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfo_pkg::CFG_CANVAS_WIDTH:  cw_reg <= clamp_cols(cfg_data);
                rfo_pkg::CFG_CANVAS_HEIGHT: ch_reg <= clamp_rows(cfg_data);
                rfo_pkg::CFG_BACKGROUND:    bg_reg <= cfg_data[rfo_pkg::CHAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            addr_reg      <= '0;
            row_base_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            step_reg      <= '0;
            char_reg      <= rfo_pkg::RESET_BG;
            outline_reg   <= 1'b0;
            sweep_cmd_reg <= 1'b0;
            is_read_reg   <= 1'b0;
            status_reg    <= rfo_pkg::ST_DONE;
            row_edge_reg  <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
            xe_reg        <= '0;
            ye_reg        <= '0;
            xl_reg        <= '0;
            yl_reg        <= '0;
            xh_reg        <= '0;
            yh_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_status_reg <= '0;
            out_char_reg  <= '0;
        end
        else
        begin
            if (rsp_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_SWEEP:
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (addr_reg == ADDR_W'(DEPTH - 1))
                        state_reg <= sweep_cmd_reg ? S_DONE : S_IDLE;
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg  <= rfo_pkg::ST_DONE;
                        is_read_reg <= 1'b0;
                        case (req.op)
                            rfo_pkg::OP_CLEAR:
                            begin
                                char_reg      <= bg_reg;
                                addr_reg      <= '0;
                                sweep_cmd_reg <= 1'b1;
                                state_reg     <= S_SWEEP;
                            end
                            rfo_pkg::OP_FILL, rfo_pkg::OP_OUTLINE:
                            begin
                                if (req.rect_width <= 20'sd0 || req.rect_height <= 20'sd0)
                                begin
                                    status_reg <= rfo_pkg::ST_SIZE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    x_reg        <= CW'(req.rect_left);
                                    y_reg        <= CW'(req.rect_top);
                                    w_reg        <= CW'(req.rect_width);
                                    h_reg        <= CW'(req.rect_height);
                                    char_reg     <= req.fill_char;
                                    outline_reg  <= (req.op == rfo_pkg::OP_OUTLINE);
                                    step_reg     <= '0;
                                    row_reg      <= '0;
                                    row_base_reg <= '0;
                                    state_reg    <= S_SETUP;
                                end
                            end
                            rfo_pkg::OP_READ:
                            begin
                                if (32'(req.read_col) >= 32'(cw_reg) ||
                                    32'(req.read_row) >= 32'(ch_reg))
                                begin
                                    status_reg <= rfo_pkg::ST_RANGE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    addr_reg    <= ADDR_W'(32'(req.read_row) * MAX_COLS +
                                                           32'(req.read_col));
                                    is_read_reg <= 1'b1;
                                    state_reg   <= S_RDDATA;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_SETUP:
                begin
                    case (step_reg)
                        3'd0:    xe_reg <= add_sum;
                        3'd1:    ye_reg <= add_sum;
                        3'd2:    xl_reg <= add_sum;
                        3'd3:    yl_reg <= add_sum;
                        3'd4:    xh_reg <= add_sum;
                        3'd5:    yh_reg <= add_sum;
                        default:
                        begin
                        end
                    endcase
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'(SETUP_STEPS - 1))
                        state_reg <= S_ROW;
                end

                S_ROW:
                begin
                    row_edge_reg <= row_edge;
                    col_reg      <= '0;
                    addr_reg     <= row_base_reg;
                    if (row_in)
                        state_reg <= S_SCAN;
                    else if (row_last)
                        state_reg <= S_DONE;
                    else
                    begin
                        row_reg      <= row_reg + ROW_W'(1);
                        row_base_reg <= row_base_reg + ADDR_W'(MAX_COLS);
                    end
                end

                S_SCAN:
                begin
                    col_reg  <= col_reg + COL_W'(1);
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (col_last)
                    begin
                        if (row_last)
                            state_reg <= S_DONE;
                        else
                        begin
                            row_reg      <= row_reg + ROW_W'(1);
                            row_base_reg <= row_base_reg + ADDR_W'(MAX_COLS);
                            state_reg    <= S_ROW;
                        end
                    end
                end

                S_RDDATA:
                begin
                    state_reg <= S_RDWAIT;
                end

                S_RDWAIT:
                begin
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (rsp_load)
                    begin
                        out_status_reg <= status_reg;
                        out_char_reg   <= is_read_reg ? rd_data_reg : '0;
                        sweep_cmd_reg  <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.cell_char = out_char_reg;

    // scan address tracks row base plus column
    a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (addr_reg == row_base_reg + ADDR_W'(col_reg)))
        else $error("scan address out of step with row and column");

    // draw writes stay inside the canvas in use
    a_draw_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && mem_we) |-> (col_reg < cw_reg && row_reg < ch_reg))
        else $error("draw write outside canvas");

    // a response only comes out of the done state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("response raised outside done state");

    // no request taken while the canvas is being swept
    a_sweep_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !req.ready)
        else $error("request taken during sweep");

    // read data only reported for a read that passed the range check
    a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != rfo_pkg::ST_DONE) |-> (rsp.cell_char == '0))
        else $error("character reported with error status");

endmodule
